/* sv/tpid_pkg.sv */
// constants and register indexes of the temperature pid controller
package tpid_pkg;

	// accumulator width of the shared serial datapath
	localparam int ACC_W = 42;
	localparam int CNT_W = 6;
	localparam int CFG_W = 23;

	// configuration register indexes
	localparam logic [2:0] REG_PERIOD = 3'd0;
	localparam logic [2:0] REG_TARGET = 3'd1;
	localparam logic [2:0] REG_KP     = 3'd2;
	localparam logic [2:0] REG_KD     = 3'd3;
	localparam logic [2:0] REG_KI_FAR = 3'd4;
	localparam logic [2:0] REG_KI_NR  = 3'd5;
	localparam logic [2:0] REG_LIMIT  = 3'd6;

	// configuration reset values
	localparam logic [15:0] RST_PERIOD = 16'd60;
	localparam logic [15:0] RST_TARGET = 16'd8960;
	localparam logic [15:0] RST_KP     = 16'd3968;
	localparam logic [15:0] RST_KD     = 16'd2304;
	localparam logic [15:0] RST_KI_FAR = 16'd0;
	localparam logic [15:0] RST_KI_NR  = 16'd754;
	localparam logic [22:0] RST_LIMIT  = 23'd1780869;
	localparam logic [15:0] RST_PREV_T = 16'd7168;

	// temperature conversion: 6 * 208563200 plus half of 100000
	localparam logic signed [ACC_W-1:0] TEMP_BIAS = 42'sd1251429200;
	localparam logic [15:0] W_PREV = 16'd40000;
	localparam logic signed [ACC_W-1:0] W_ADC = -42'sd420864;
	localparam logic [17:0] DIV_TEMP = 18'd100000;
	localparam logic [17:0] DIV_DER  = 18'd5;

	// bands in q8.8
	localparam logic [16:0] BAND_TOL  = 17'd38;
	localparam logic [16:0] BAND_NEAR = 17'd384;
	localparam logic [16:0] BAND_HI   = 17'd256;
	localparam logic [16:0] BAND_MID  = 17'd128;
	localparam logic [16:0] BAND_LO   = 17'd77;
	localparam logic [ACC_W-1:0] OFS_HI = 42'd786432;  // 12 in q16.16
	localparam logic [ACC_W-1:0] OFS_LO = 42'd458752;  // 7 in q16.16

	// drive limits
	localparam logic signed [15:0] DRIVE_BAND = 16'sd4608;
	localparam logic signed [15:0] DRIVE_FULL = 16'sd25600;
	localparam logic signed [ACC_W-1:0] DRIVE_KNEE = 42'sd15360;

endpackage

/* sv/temperature_pid_controller.sv */
// temperature pid controller with integral separation, bit-serial datapath
//
//  channel | signals                                       | transfer when
//  --------+-----------------------------------------------+-----------------------
//  cfg     | cfg_we, cfg_index, cfg_data                   | cfg_we high
//  in      | in_valid, in_ready, adc_sample                | in_valid && in_ready
//  out     | out_valid, out_ready, drive, temperature,     | out_valid && out_ready
//          | integral_term, in_band                        |
//
// a tick without an update is taken and leaves the sequencer idle; an update runs from the
// tick transfer to the result through the shared serial multiplier and the restoring
// constant divider, and an in-band update skips the integral, derivative and drive steps.
// in_ready is high only while the sequencer is idle.
// the result sits in an output register; a new tick is taken while it waits,
// and an update that finishes meanwhile holds until the output is free.
// arst_n clears control state and loads the register and state reset values.
module temperature_pid_controller
	import tpid_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [11:0]         adc_sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  drive,
	output logic signed [15:0]  temperature,
	output logic signed [15:0]  integral_term,
	output logic                in_band
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MT1   = 4'd1;
	localparam logic [3:0] S_MT2   = 4'd2;
	localparam logic [3:0] S_DLD   = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_TEMP  = 4'd5;
	localparam logic [3:0] S_ERR   = 4'd6;
	localparam logic [3:0] S_SUM   = 4'd7;
	localparam logic [3:0] S_MKI   = 4'd8;
	localparam logic [3:0] S_ITERM = 4'd9;
	localparam logic [3:0] S_MKD   = 4'd10;
	localparam logic [3:0] S_DS    = 4'd11;
	localparam logic [3:0] S_PRE   = 4'd12;
	localparam logic [3:0] S_MKP   = 4'd13;
	localparam logic [3:0] S_DRV   = 4'd14;
	localparam logic [3:0] S_OUT   = 4'd15;

	localparam logic signed [ACC_W-1:0] MAX16 = 42'sd32767;
	localparam logic signed [ACC_W-1:0] MIN16 = -42'sd32768;
	localparam logic signed [ACC_W-1:0] MAX32 = 42'sd2147483647;
	localparam logic signed [ACC_W-1:0] MIN32 = -42'sd2147483648;

	// configuration registers
	logic [15:0]        period_q;
	logic signed [15:0] target_q;
	logic [15:0]        kp_q;
	logic [15:0]        kd_q;
	logic [15:0]        ki_far_q;
	logic [15:0]        ki_near_q;
	logic [22:0]        limit_q;

	// controller state
	logic [15:0]        tick_q;
	logic signed [15:0] prev_temp_q;
	logic signed [15:0] prev_err_q;
	logic signed [23:0] esum_q;
	logic signed [31:0] ds_q;

	// working registers
	logic [3:0]               state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [11:0]              adc_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  mcand_q;
	logic [15:0]              mult_q;
	logic [ACC_W-1:0]         num_q;
	logic [16:0]              rem_q;
	logic                     neg_q;
	logic                     div5_q;
	logic signed [15:0]       temp_q;
	logic signed [15:0]       err_q;
	logic signed [16:0]       diff_q;
	logic [16:0]              aerr_q;
	logic signed [15:0]       iterm_q;
	logic signed [15:0]       drive_q;
	logic                     band_q;

	// output register
	logic                     out_valid_q;
	logic signed [15:0]       drive_o_q;
	logic signed [15:0]       temp_o_q;
	logic signed [15:0]       iterm_o_q;
	logic                     band_o_q;

	function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
		logic signed [15:0] r;
		if (v > MAX16) r = 16'sh7fff;
		else if (v < MIN16) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > MAX32) r = 32'sh7fffffff;
		else if (v < MIN32) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// multiplier and divider step logic
	logic signed [ACC_W-1:0] acc_step;
	logic [17:0]             div_d;
	logic [17:0]             div_t;
	logic                    div_ge;
	logic [17:0]             div_r;
	logic signed [ACC_W-1:0] dmag;
	logic signed [ACC_W-1:0] quot;
	logic [15:0]             tick_inc;

	always_comb begin
		acc_step = acc_q + (mult_q[0] ? mcand_q : '0);
		div_d = div5_q ? DIV_DER : DIV_TEMP;
		div_t = {rem_q, num_q[ACC_W-1]};
		div_ge = (div_t >= div_d);
		div_r = div_ge ? (div_t - div_d) : div_t;
		// floor division of a negative value through its magnitude
		dmag = acc_q[ACC_W-1] ? (-acc_q + $signed({24'd0, div_d - 18'd1})) : acc_q;
		quot = neg_q ? -$signed(num_q) : $signed(num_q);
		tick_inc = tick_q + 16'd1;
	end

	// error, band and integral logic
	logic signed [16:0] err17;
	logic signed [15:0] err_n;
	logic [15:0]        ki_sel;
	logic signed [24:0] sum25;
	logic signed [24:0] lim25;
	logic signed [23:0] sum_n;
	logic [ACC_W-1:0]   offset;
	logic signed [ACC_W-1:0] dsh;

	always_comb begin
		err17 = {target_q[15], target_q} - {temp_q[15], temp_q};
		if (err17 > 17'sd32767) err_n = 16'sh7fff;
		else if (err17 < -17'sd32768) err_n = 16'sh8000;
		else err_n = err17[15:0];

		ki_sel = (aerr_q < BAND_NEAR) ? ki_near_q : ki_far_q;
		lim25 = $signed({2'b00, limit_q});
		sum25 = (ki_sel != 16'd0) ? ({esum_q[23], esum_q} + {{9{err_q[15]}}, err_q}) : 25'sd0;
		if (sum25 > lim25) sum_n = lim25[23:0];
		else if (sum25 < -lim25) sum_n = 24'(-lim25);
		else sum_n = sum25[23:0];

		if (aerr_q > BAND_MID && aerr_q < BAND_HI) offset = OFS_HI;
		else if (aerr_q >= BAND_LO && aerr_q < BAND_MID) offset = OFS_LO;
		else offset = '0;

		dsh = acc_q >>> 8;
	end

	assign in_ready = (state_q == S_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= RST_PERIOD;
			target_q  <= RST_TARGET;
			kp_q      <= RST_KP;
			kd_q      <= RST_KD;
			ki_far_q  <= RST_KI_FAR;
			ki_near_q <= RST_KI_NR;
			limit_q   <= RST_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERIOD: period_q  <= cfg_data[15:0];
				REG_TARGET: target_q  <= cfg_data[15:0];
				REG_KP:     kp_q      <= cfg_data[15:0];
				REG_KD:     kd_q      <= cfg_data[15:0];
				REG_KI_FAR: ki_far_q  <= cfg_data[15:0];
				REG_KI_NR:  ki_near_q <= cfg_data[15:0];
				REG_LIMIT:  limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tick_q      <= '0;
			prev_temp_q <= RST_PREV_T;
			prev_err_q  <= '0;
			esum_q      <= '0;
			ds_q        <= '0;
			cnt_q       <= '0;
			div5_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// the output step reloads the register itself
			if (out_valid_q && out_ready && state_q != S_OUT) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (tick_inc < period_q) begin
							tick_q <= tick_inc;
						end else begin
							tick_q  <= '0;
							adc_q   <= adc_sample;
							acc_q   <= TEMP_BIAS;
							mcand_q <= ACC_W'(prev_temp_q);
							mult_q  <= W_PREV;
							cnt_q   <= CNT_W'(15);
							state_q <= S_MT1;
						end
					end
				end
				S_MT1, S_MT2, S_MKI, S_MKD, S_MKP: begin
					acc_q <= acc_step;
					if (cnt_q != '0) begin
						mcand_q <= mcand_q <<< 1;
						mult_q  <= mult_q >> 1;
						cnt_q   <= cnt_q - CNT_W'(1);
					end else begin
						case (state_q)
							S_MT1: begin
								mcand_q <= W_ADC;
								mult_q  <= {4'd0, adc_q};
								cnt_q   <= CNT_W'(15);
								state_q <= S_MT2;
							end
							S_MT2: begin
								div5_q  <= 1'b0;
								state_q <= S_DLD;
							end
							S_MKI:   state_q <= S_ITERM;
							S_MKD: begin
								div5_q  <= 1'b1;
								state_q <= S_DLD;
							end
							default: state_q <= S_DRV;
						endcase
					end
				end
				S_DLD: begin
					neg_q   <= acc_q[ACC_W-1];
					num_q   <= dmag;
					rem_q   <= '0;
					cnt_q   <= CNT_W'(ACC_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring division, one quotient bit per cycle
					rem_q <= div_r[16:0];
					num_q <= {num_q[ACC_W-2:0], div_ge};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) state_q <= div5_q ? S_DS : S_TEMP;
				end
				S_TEMP: begin
					temp_q      <= sat16(quot);
					prev_temp_q <= sat16(quot);
					state_q     <= S_ERR;
				end
				S_ERR: begin
					err_q      <= err_n;
					diff_q     <= {err_n[15], err_n} - {prev_err_q[15], prev_err_q};
					prev_err_q <= err_n;
					aerr_q     <= err_n[15] ? 17'(-{err_n[15], err_n}) : {1'b0, err_n};
					state_q    <= S_SUM;
				end
				S_SUM: begin
					if (aerr_q <= BAND_TOL) begin
						esum_q  <= '0;
						iterm_q <= '0;
						drive_q <= DRIVE_BAND;
						band_q  <= 1'b1;
						state_q <= S_OUT;
					end else begin
						esum_q  <= sum_n;
						acc_q   <= 42'sd32768;
						mcand_q <= ACC_W'(sum_n);
						mult_q  <= ki_sel;
						cnt_q   <= CNT_W'(15);
						state_q <= S_MKI;
					end
				end
				S_ITERM: begin
					iterm_q <= sat16(acc_q >>> 16);
					acc_q   <= (ACC_W'(ds_q) <<< 2) + 42'sd2;
					mcand_q <= ACC_W'(diff_q);
					mult_q  <= kd_q;
					cnt_q   <= CNT_W'(15);
					state_q <= S_MKD;
				end
				S_DS: begin
					ds_q    <= sat32(quot);
					state_q <= S_PRE;
				end
				S_PRE: begin
					acc_q   <= (ACC_W'(iterm_q) <<< 8) + ACC_W'(ds_q) + $signed(offset)
						+ 42'sd128;
					mcand_q <= ACC_W'(err_q);
					mult_q  <= kp_q;
					cnt_q   <= CNT_W'(15);
					state_q <= S_MKP;
				end
				S_DRV: begin
					if (dsh > DRIVE_KNEE) drive_q <= DRIVE_FULL;
					else if (dsh < -DRIVE_KNEE) drive_q <= -DRIVE_FULL;
					else drive_q <= dsh[15:0];
					band_q  <= 1'b0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						drive_o_q   <= drive_q;
						temp_o_q    <= temp_q;
						iterm_o_q   <= iterm_q;
						band_o_q    <= band_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign drive         = drive_o_q;
	assign temperature   = temp_o_q;
	assign integral_term = iterm_o_q;
	assign in_band       = band_o_q;

	// an in-band result carries the fixed drive and no integral part
	a_band_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_band |-> drive == DRIVE_BAND && integral_term == 16'sd0)
		else $error("in-band result with wrong drive or integral");

	// drive is either inside the knee or at full scale
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive <= 16'sd15360 && drive >= -16'sd15360)
		|| drive == DRIVE_FULL || drive == -DRIVE_FULL)
		else $error("drive outside its allowed values");

	// a new result only comes from the output step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside the output step");

endmodule
